### sv/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg - shared types and constants of the bounding sphere merge
// Lane operation codes, square root control and the step counts of the
// bit-serial units.
// ----------------------------------------------------------------------------
package bsm_pkg;

    // Operation applied to one axis lane in a cycle
    typedef enum logic [2:0] {
        LANE_IDLE  = 3'd0,
        LANE_LOAD  = 3'd1,
        LANE_MUL   = 3'd2,
        LANE_SETF  = 3'd3,
        LANE_DIVLD = 3'd4,
        LANE_DIV   = 3'd5
    } t_lane_op;

    // Square root unit control
    typedef struct packed {
        logic load;
        logic step;
    } t_sqrt_ctl;

    // Result codes
    localparam logic [1:0] OUTCOME_KEEP    = 2'd0;
    localparam logic [1:0] OUTCOME_REPLACE = 2'd1;
    localparam logic [1:0] OUTCOME_GROW    = 2'd2;

    // Bit-serial step counts
    localparam int MUL_STEPS  = 34;  // multiplier bits of the shift-add
    localparam int ROOT_STEPS = 33;  // root bits of a 66 bit radicand
    localparam int DIV_STEPS  = 33;  // quotient bits of the axis move
    localparam int CNT_W      = 6;

endpackage

### sv/bsm_lane.sv
// ----------------------------------------------------------------------------
// bsm_lane - one axis of the merge
// Forms the centre difference, squares it and later scales it by
// (L + rd) / 2L with a shift-add multiplier and a restoring divider, one bit
// per cycle, then applies the move to the stored centre.
// ----------------------------------------------------------------------------
module bsm_lane (
    input  logic                i_clk,
    input  bsm_pkg::t_lane_op   i_op,
    input  logic [31:0]         i_c,
    input  logic [31:0]         i_p,
    input  logic [33:0]         i_f,
    input  logic [33:0]         i_den,
    output logic [63:0]         o_sq,
    output logic [31:0]         o_center
);

    logic [31:0] r_c;
    logic        r_neg;
    logic [31:0] r_mcand;
    logic [33:0] r_mplier;
    logic [65:0] r_acc;
    logic [33:0] r_rem;

    logic [32:0] diff;
    logic [32:0] diff_neg;
    logic [31:0] mag;
    logic [32:0] add_sum;
    logic [34:0] div_trial;
    logic [34:0] div_diff;
    logic        div_ge;

    // signed difference and its magnitude
    assign diff     = {i_p[31], i_p} - {i_c[31], i_c};
    assign diff_neg = -diff;
    assign mag      = diff[32] ? diff_neg[31:0] : diff[31:0];

    // shift-add: add the multiplicand into the top when the low bit is set
    assign add_sum = {1'b0, r_acc[65:34]} + {1'b0, (r_mplier[0] ? r_mcand : 32'd0)};

    // restoring division step
    assign div_trial = {r_rem, r_acc[32]};
    assign div_ge    = (div_trial >= {1'b0, i_den});
    assign div_diff  = div_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        case (i_op)
            bsm_pkg::LANE_LOAD: begin
                r_c      <= i_c;
                r_neg    <= diff[32];
                r_mcand  <= mag;
                r_mplier <= {2'b00, mag};
                r_acc    <= '0;
            end
            bsm_pkg::LANE_MUL: begin
                r_acc    <= {add_sum, r_acc[33:1]};
                r_mplier <= {1'b0, r_mplier[33:1]};
            end
            bsm_pkg::LANE_SETF: begin
                r_mplier <= i_f;
                r_acc    <= '0;
            end
            bsm_pkg::LANE_DIVLD: begin
                r_rem <= {1'b0, r_acc[65:33]};
            end
            bsm_pkg::LANE_DIV: begin
                r_rem <= div_ge ? div_diff[33:0] : div_trial[33:0];
                r_acc <= {r_acc[65:33], r_acc[31:0], div_ge};
            end
            default: begin
            end
        endcase
    end

    // quotient never exceeds the magnitude, so 32 bits carry the move
    assign o_sq     = r_acc[63:0];
    assign o_center = r_neg ? (r_c - r_acc[31:0]) : (r_c + r_acc[31:0]);

endmodule

### sv/bsm_sqrt.sv
// ----------------------------------------------------------------------------
// bsm_sqrt - bit-serial integer square root
// Digit-by-digit restoring root of a 66 bit radicand, one root bit per
// cycle while step is set; flags an exact square through a zero remainder.
// ----------------------------------------------------------------------------
module bsm_sqrt (
    input  logic                i_clk,
    input  bsm_pkg::t_sqrt_ctl  i_ctl,
    input  logic [65:0]         i_radicand,
    output logic [32:0]         o_root,
    output logic                o_rem_zero
);

    logic [65:0] r_rad;
    logic [33:0] r_rem;
    logic [32:0] r_root;

    logic [35:0] trial_rem;
    logic [34:0] trial_sub;
    logic [35:0] diff;
    logic        ge;

    // bring down the next pair and try the root with a one appended
    assign trial_rem = {r_rem, r_rad[65:64]};
    assign trial_sub = {r_root, 2'b01};
    assign ge        = (trial_rem >= {1'b0, trial_sub});
    assign diff      = trial_rem - {1'b0, trial_sub};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctl.step) begin
            r_rad  <= {r_rad[63:0], 2'b00};
            r_rem  <= ge ? diff[33:0] : trial_rem[33:0];
            r_root <= {r_root[31:0], ge};
        end
    end

    assign o_root     = r_root;
    assign o_rem_zero = (r_rem == 34'd0);

endmodule

### sv/bounding_sphere_merge.sv
// ----------------------------------------------------------------------------
// bounding_sphere_merge - running bounding sphere in Q16.16
// Keeps one sphere and grows it to enclose each incoming sphere, or loads the
// incoming sphere when restart is set. One item is worked on at a time. A
// restart item goes straight to the output register; a merge squares the
// centre differences in the three axis lanes, sums them, takes the square
// root and ends there on containment, while a merge that grows the sphere
// then multiplies and divides in the lanes, all in bit-serial units. The
// next input is taken while a finished result still waits in the output
// register. Every rounding is toward zero; a grown radius saturates at its
// largest value.
// ----------------------------------------------------------------------------
module bounding_sphere_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_restart,
    input  logic [31:0] i_in_center_x,
    input  logic [31:0] i_in_center_y,
    input  logic [31:0] i_in_center_z,
    input  logic [30:0] i_in_radius,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_out_center_x,
    output logic [31:0] o_out_center_y,
    output logic [31:0] o_out_center_z,
    output logic [30:0] o_out_radius,
    output logic [1:0]  o_outcome
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SQR    = 10'b00_0000_0010,
        S_SUM0   = 10'b00_0000_0100,
        S_SUM1   = 10'b00_0000_1000,
        S_ROOT   = 10'b00_0001_0000,
        S_DECIDE = 10'b00_0010_0000,
        S_MUL    = 10'b00_0100_0000,
        S_DIVLD  = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } t_state;

    localparam logic [bsm_pkg::CNT_W-1:0] MUL_LAST  =
        bsm_pkg::CNT_W'(bsm_pkg::MUL_STEPS - 1);
    localparam logic [bsm_pkg::CNT_W-1:0] ROOT_LAST =
        bsm_pkg::CNT_W'(bsm_pkg::ROOT_STEPS - 1);
    localparam logic [bsm_pkg::CNT_W-1:0] DIV_LAST  =
        bsm_pkg::CNT_W'(bsm_pkg::DIV_STEPS - 1);
    localparam logic [30:0] RADIUS_ONE = 31'(64'd1 << FRAC_BITS);

    // control
    t_state                    r_state, n_state;
    logic [bsm_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_out_valid;

    // stored sphere
    logic [31:0] r_cx, r_cy, r_cz;
    logic [30:0] r_rad;

    // item working registers
    logic [31:0] r_ix, r_iy, r_iz;
    logic [30:0] r_ir;
    logic [31:0] r_rd;
    logic [1:0]  r_outcome;
    logic [30:0] r_nr;
    logic [33:0] r_den;
    logic [65:0] r_lsq;

    // output register
    logic [31:0] r_ox, r_oy, r_oz;
    logic [30:0] r_or;
    logic [1:0]  r_oo;

    logic               in_xfer;
    logic               commit;
    bsm_pkg::t_lane_op  lane_op;
    bsm_pkg::t_sqrt_ctl sq_ctl;
    logic [63:0]        sq_x, sq_y, sq_z;
    logic [31:0]        mv_x, mv_y, mv_z;
    logic [32:0]        root;
    logic               rem_zero;
    logic [31:0]        rd_neg;
    logic [30:0]        rd_mag;
    logic               rd_pos;
    logic               contain;
    logic [33:0]        f_val;
    logic [33:0]        nr_sum;
    logic [30:0]        nr_sat;
    logic [31:0]        n_cx, n_cy, n_cz;
    logic [30:0]        n_rad;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // axis lanes
    bsm_lane u_lane_x (
        .i_clk    (i_clk),
        .i_op     (lane_op),
        .i_c      (r_cx),
        .i_p      (i_in_center_x),
        .i_f      (f_val),
        .i_den    (r_den),
        .o_sq     (sq_x),
        .o_center (mv_x)
    );

    bsm_lane u_lane_y (
        .i_clk    (i_clk),
        .i_op     (lane_op),
        .i_c      (r_cy),
        .i_p      (i_in_center_y),
        .i_f      (f_val),
        .i_den    (r_den),
        .o_sq     (sq_y),
        .o_center (mv_y)
    );

    bsm_lane u_lane_z (
        .i_clk    (i_clk),
        .i_op     (lane_op),
        .i_c      (r_cz),
        .i_p      (i_in_center_z),
        .i_f      (f_val),
        .i_den    (r_den),
        .o_sq     (sq_z),
        .o_center (mv_z)
    );

    // distance root
    bsm_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_ctl      (sq_ctl),
        .i_radicand (r_lsq + {2'b00, sq_z}),
        .o_root     (root),
        .o_rem_zero (rem_zero)
    );

    // containment: squared distance at most rd squared
    assign rd_neg  = -r_rd;
    assign rd_mag  = r_rd[31] ? rd_neg[30:0] : r_rd[30:0];
    assign rd_pos  = !r_rd[31] && (r_rd != 32'd0);
    assign contain = (root < {2'b00, rd_mag}) ||
                     ((root == {2'b00, rd_mag}) && rem_zero);

    // move fraction numerator and grown radius
    assign f_val  = {1'b0, root} + {{2{r_rd[31]}}, r_rd};
    assign nr_sum = {1'b0, root} + {3'b000, r_rad} + {3'b000, r_ir};
    assign nr_sat = (nr_sum[33:32] != 2'b00) ? 31'h7FFF_FFFF : nr_sum[31:1];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        lane_op = bsm_pkg::LANE_IDLE;
        sq_ctl  = '0;
        commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    lane_op = bsm_pkg::LANE_LOAD;
                    n_cnt   = MUL_LAST;
                    n_state = i_restart ? S_OUT : S_SQR;
                end
            end
            S_SQR: begin
                lane_op = bsm_pkg::LANE_MUL;
                if (r_cnt == '0) begin
                    n_state = S_SUM0;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SUM0: begin
                n_state = S_SUM1;
            end
            S_SUM1: begin
                sq_ctl.load = 1'b1;
                n_cnt       = ROOT_LAST;
                n_state     = S_ROOT;
            end
            S_ROOT: begin
                sq_ctl.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DECIDE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DECIDE: begin
                if (contain) begin
                    n_state = S_OUT;
                end else begin
                    lane_op = bsm_pkg::LANE_SETF;
                    n_cnt   = MUL_LAST;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                lane_op = bsm_pkg::LANE_MUL;
                if (r_cnt == '0) begin
                    n_state = S_DIVLD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DIVLD: begin
                lane_op = bsm_pkg::LANE_DIVLD;
                n_cnt   = DIV_LAST;
                n_state = S_DIV;
            end
            S_DIV: begin
                lane_op = bsm_pkg::LANE_DIV;
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sphere after this item
    always_comb begin
        n_cx  = r_cx;
        n_cy  = r_cy;
        n_cz  = r_cz;
        n_rad = r_rad;
        case (r_outcome)
            bsm_pkg::OUTCOME_REPLACE: begin
                n_cx  = r_ix;
                n_cy  = r_iy;
                n_cz  = r_iz;
                n_rad = r_ir;
            end
            bsm_pkg::OUTCOME_GROW: begin
                n_cx  = mv_x;
                n_cy  = mv_y;
                n_cz  = mv_z;
                n_rad = r_nr;
            end
            default: begin
            end
        endcase
    end

    // control and stored sphere
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_cz        <= '0;
            r_rad       <= RADIUS_ONE;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (commit) begin
                r_out_valid <= 1'b1;
                r_cx        <= n_cx;
                r_cy        <= n_cy;
                r_cz        <= n_cz;
                r_rad       <= n_rad;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and intermediate results
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ix      <= i_in_center_x;
            r_iy      <= i_in_center_y;
            r_iz      <= i_in_center_z;
            r_ir      <= i_in_radius;
            r_rd      <= {1'b0, i_in_radius} - {1'b0, r_rad};
            r_outcome <= bsm_pkg::OUTCOME_REPLACE;
        end
        if (r_state == S_SUM0) begin
            r_lsq <= {2'b00, sq_x} + {2'b00, sq_y};
        end
        if (r_state == S_DECIDE) begin
            r_den <= {root, 1'b0};
            r_nr  <= nr_sat;
            if (!contain) begin
                r_outcome <= bsm_pkg::OUTCOME_GROW;
            end else if (rd_pos) begin
                r_outcome <= bsm_pkg::OUTCOME_REPLACE;
            end else begin
                r_outcome <= bsm_pkg::OUTCOME_KEEP;
            end
        end
        if (commit) begin
            r_ox <= n_cx;
            r_oy <= n_cy;
            r_oz <= n_cz;
            r_or <= n_rad;
            r_oo <= r_outcome;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_center_x = r_ox;
    assign o_out_center_y = r_oy;
    assign o_out_center_z = r_oz;
    assign o_out_radius   = r_or;
    assign o_outcome      = r_oo;

endmodule
